@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent on one edge implies consequent on the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// Types, widths and codes for the length prefixed packet ring.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int RING_CAPACITY = 32768;
  localparam int PTR_W         = $clog2(RING_CAPACITY);
  localparam int CMP_W         = (PTR_W > 16) ? PTR_W : 16;
  localparam int LEN_W         = 12;
  localparam int HLEN_W        = 16;
  localparam int USED_W        = 15;

  localparam logic [PTR_W-1:0] PTR_MASK      = '1;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd2048;

  localparam logic [1:0] CMD_PUSH_START = 2'd0;
  localparam logic [1:0] CMD_PUSH_BYTE  = 2'd1;
  localparam logic [1:0] CMD_POP_BYTE   = 2'd2;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_FILLING  = 2'd1;
  localparam logic [1:0] MODE_DROPPING = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_NO_ROOM    = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_IGNORED    = 3'd4;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        out_byte;
    logic              last_byte;
    logic [HLEN_W-1:0] header_length;
    logic [USED_W-1:0] used_bytes;
    logic [USED_W-1:0] free_bytes;
  } out_item_t;

endpackage

@@ hdl/lpr_if.sv @@
// ----------------------------------------------------------------------------
// lpr_if
// Valid/ready channels of the packet ring: items in, results out, config.
// ----------------------------------------------------------------------------
interface lpr_in_if;
  logic              valid;
  logic              ready;
  lpr_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lpr_out_if;
  logic               valid;
  logic               ready;
  lpr_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lpr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lpr_pkg::LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/lpr_ram.sv @@
// ----------------------------------------------------------------------------
// lpr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/length_prefixed_packet_ring.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring
// Byte ring holding whole packets behind a two-byte little-endian length
// header, with one slot kept free.
//
//   channel   dir  fields
//   request   in   command, data_byte, packet_length
//   result    out  status, out_byte, last_byte, header_length,
//                  used_bytes, free_bytes
//   cfg       in   data (max_packet_length), always ready
//
// Each request ends in S_EMIT, and a new request is taken only in S_IDLE.
// An accepted push_start also passes S_HDR_HI (two header writes on the one
// write port). The first pop of a packet passes S_HDR_LO and S_HDR_CHK (header
// and first byte read back to back through the registered read port).
// Reset is synchronous; the byte store is not cleared. A stalled result holds
// in the output register while the next request is already accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module length_prefixed_packet_ring (
  input  logic            clk,
  input  logic            rst,
  lpr_in_if.sink          request,
  lpr_out_if.source       result,
  lpr_cfg_if.sink         cfg
);

  localparam int PTR_W  = lpr_pkg::PTR_W;
  localparam int CMP_W  = lpr_pkg::CMP_W;
  localparam int LEN_W  = lpr_pkg::LEN_W;
  localparam int HLEN_W = lpr_pkg::HLEN_W;
  localparam int USED_W = lpr_pkg::USED_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_HDR_HI  = 3'd1;
  localparam logic [2:0] S_HDR_LO  = 3'd2;
  localparam logic [2:0] S_HDR_CHK = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]       state, state_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] wp, wp_next;
  logic [LEN_W-1:0] wrem, wrem_next;
  logic [1:0]       mode, mode_next;
  logic [LEN_W-1:0] rrem, rrem_next;
  logic [LEN_W-1:0] max_len;
  logic [LEN_W-1:0] len_q;
  logic [7:0]       hdr_lo;

  logic [2:0]        res_status, res_status_next;
  logic              res_last, res_last_next;
  logic [HLEN_W-1:0] res_hlen, res_hlen_next;
  logic              res_take, res_take_next;

  logic                out_valid;
  lpr_pkg::out_item_t  out_q;

  logic             we, re;
  logic [PTR_W-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata;

  logic             acc, load;
  logic [PTR_W-1:0] used, room;
  logic [LEN_W-1:0] len_in;
  logic [HLEN_W-1:0] hlen;

  lpr_ram #(.WIDTH(8), .DEPTH(lpr_pkg::RING_CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign request.ready  = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign result.valid   = out_valid;
  assign result.payload = out_q;

  assign acc    = request.valid && request.ready;
  assign len_in = request.payload.packet_length;
  assign used   = tail - rp;
  assign room   = lpr_pkg::PTR_MASK - used;
  assign hlen   = {rdata, hdr_lo};
  assign load   = (state == S_EMIT) && (!out_valid || result.ready);

  always_comb begin
    state_next      = state;
    rp_next         = rp;
    tail_next       = tail;
    wp_next         = wp;
    wrem_next       = wrem;
    mode_next       = mode;
    rrem_next       = rrem;
    res_status_next = res_status;
    res_last_next   = res_last;
    res_hlen_next   = res_hlen;
    res_take_next   = res_take;
    we              = 1'b0;
    waddr           = wp;
    wdata           = request.payload.data_byte;
    re              = 1'b0;
    raddr           = rp;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next      = S_EMIT;
          res_status_next = lpr_pkg::ST_IGNORED;
          res_last_next   = 1'b0;
          res_hlen_next   = '0;
          res_take_next   = 1'b0;
          case (request.payload.command)
            lpr_pkg::CMD_PUSH_START: begin
              wp_next   = tail;
              mode_next = lpr_pkg::MODE_IDLE;
              wrem_next = '0;
              if (len_in == '0 || len_in > max_len) begin
                res_status_next = lpr_pkg::ST_BAD_LENGTH;
              end else if (CMP_W'(room) < CMP_W'(len_in) + CMP_W'(2)) begin
                res_status_next = lpr_pkg::ST_NO_ROOM;
                mode_next       = lpr_pkg::MODE_DROPPING;
                wrem_next       = len_in;
              end else begin
                we              = 1'b1;
                waddr           = tail;
                wdata           = len_in[7:0];
                wp_next         = tail + 1'b1;
                wrem_next       = len_in;
                mode_next       = lpr_pkg::MODE_FILLING;
                res_status_next = lpr_pkg::ST_OK;
                state_next      = S_HDR_HI;
              end
            end
            lpr_pkg::CMD_PUSH_BYTE: begin
              if (mode == lpr_pkg::MODE_FILLING && wrem != '0) begin
                we              = 1'b1;
                waddr           = wp;
                wp_next         = wp + 1'b1;
                wrem_next       = wrem - 1'b1;
                res_status_next = lpr_pkg::ST_OK;
                if (wrem == LEN_W'(1)) begin
                  tail_next = wp + 1'b1;
                  mode_next = lpr_pkg::MODE_IDLE;
                end
              end else if (mode == lpr_pkg::MODE_DROPPING && wrem != '0) begin
                wrem_next       = wrem - 1'b1;
                res_status_next = lpr_pkg::ST_NO_ROOM;
                if (wrem == LEN_W'(1)) begin
                  mode_next = lpr_pkg::MODE_IDLE;
                end
              end else begin
                mode_next = lpr_pkg::MODE_IDLE;
                wrem_next = '0;
              end
            end
            lpr_pkg::CMD_POP_BYTE: begin
              if (rrem != '0) begin
                if (used == '0) begin
                  res_status_next = lpr_pkg::ST_EMPTY;
                end else begin
                  re              = 1'b1;
                  rp_next         = rp + 1'b1;
                  rrem_next       = rrem - 1'b1;
                  res_last_next   = (rrem == LEN_W'(1));
                  res_take_next   = 1'b1;
                  res_status_next = lpr_pkg::ST_OK;
                end
              end else if (used < PTR_W'(2)) begin
                res_status_next = lpr_pkg::ST_EMPTY;
              end else begin
                re         = 1'b1;
                rp_next    = rp + 1'b1;
                state_next = S_HDR_LO;
              end
            end
            default: begin
              res_status_next = lpr_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_HDR_HI: begin
        we         = 1'b1;
        waddr      = wp;
        wdata      = 8'(len_q >> 8);
        wp_next    = wp + 1'b1;
        state_next = S_EMIT;
      end
      S_HDR_LO: begin
        re         = 1'b1;
        rp_next    = rp + 1'b1;
        state_next = S_HDR_CHK;
      end
      S_HDR_CHK: begin
        res_hlen_next = hlen;
        state_next    = S_EMIT;
        if (hlen == '0 || CMP_W'(hlen) > CMP_W'(max_len) || CMP_W'(hlen) > CMP_W'(used)) begin
          res_status_next = lpr_pkg::ST_BAD_LENGTH;
        end else begin
          re              = 1'b1;
          rp_next         = rp + 1'b1;
          rrem_next       = LEN_W'(hlen - 1'b1);
          res_last_next   = (hlen == HLEN_W'(1));
          res_take_next   = 1'b1;
          res_status_next = lpr_pkg::ST_OK;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      tail      <= '0;
      wp        <= '0;
      wrem      <= '0;
      mode      <= lpr_pkg::MODE_IDLE;
      rrem      <= '0;
      max_len   <= lpr_pkg::MAX_LEN_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rp    <= rp_next;
      tail  <= tail_next;
      wp    <= wp_next;
      wrem  <= wrem_next;
      mode  <= mode_next;
      rrem  <= rrem_next;
      if (cfg.valid && cfg.ready) begin
        max_len <= cfg.data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_last   <= res_last_next;
    res_hlen   <= res_hlen_next;
    res_take   <= res_take_next;
    if (acc) begin
      len_q <= len_in;
    end
    if (state == S_HDR_LO) begin
      hdr_lo <= rdata;
    end
    if (load) begin
      out_q.status        <= res_status;
      out_q.out_byte      <= res_take ? rdata : 8'd0;
      out_q.last_byte     <= res_last;
      out_q.header_length <= res_hlen;
      out_q.used_bytes    <= USED_W'(tail - rp);
      out_q.free_bytes    <= USED_W'(lpr_pkg::PTR_MASK - (wp - rp));
    end
  end

  logic [PTR_W-1:0] wr_ofs, tail_ofs, wp_ofs;
  assign wr_ofs   = waddr - rp;
  assign tail_ofs = tail - rp;
  assign wp_ofs   = wp - rp;

  `ASSERT_IMPLIES(a_fill_has_bytes, mode == lpr_pkg::MODE_FILLING, wrem != '0, "filling with no bytes left")
  `ASSERT_IMPLIES(a_write_outside_committed, we, wr_ofs >= tail_ofs, "write into committed bytes")
  `ASSERT_ALWAYS(a_tail_behind_wp, tail_ofs <= wp_ofs, "committed tail ahead of write pointer")

endmodule
